// ===== hw/rtl/keypad_debounce_event_engine_macros.svh =====
// ---------------------------------------------------------------------------
// Keypad debounce event engine assertion macros
// Shared concurrent assertion forms, clocked on clock, quiet during reset.
// ---------------------------------------------------------------------------
`ifndef KEYPAD_DEBOUNCE_EVENT_ENGINE_MACROS_SVH
`define KEYPAD_DEBOUNCE_EVENT_ENGINE_MACROS_SVH

// condition holds at every edge
`define KDE_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define KDE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/kde_pkg.sv =====
// ---------------------------------------------------------------------------
// Keypad debounce event engine package
// Payload types, register indexes, stage codes and default sizes.
// ---------------------------------------------------------------------------
package kde_pkg;

   localparam int KDE_NUM_KEYS        = 4;
   localparam int KDE_NUM_GROUPS      = 4;
   localparam int KDE_HOLD_COUNT_BITS = 16;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_KEY_MODES      = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_KEY_GROUPS     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEBOUNCE_TICKS = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REPEAT_START   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REPEAT_PERIOD  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LONG_PRESS     = 3'd5;

   localparam logic [7:0]  DEBOUNCE_TICKS_RESET = 8'd5;
   localparam logic [15:0] REPEAT_START_RESET   = 16'd100;
   localparam logic [15:0] REPEAT_PERIOD_RESET  = 16'(50 / 5);
   localparam logic [15:0] LONG_PRESS_RESET     = 16'd200;

   // debounce stages
   localparam logic [1:0] DB_IDLE     = 2'd0;
   localparam logic [1:0] DB_PRESSING = 2'd1;
   localparam logic [1:0] DB_HELD     = 2'd2;
   localparam logic [1:0] DB_RELEASE  = 2'd3;

   // event stages
   localparam logic [3:0] ST_START        = 4'd0;
   localparam logic [3:0] ST_WAIT_RELEASE = 4'd1;
   localparam logic [3:0] ST_WAIT_READ    = 4'd2;
   localparam logic [3:0] ST_LONG         = 4'd3;
   localparam logic [3:0] ST_ON_RELEASE   = 4'd4;
   localparam logic [3:0] ST_REP_START    = 4'd5;
   localparam logic [3:0] ST_REP_ARM      = 4'd6;
   localparam logic [3:0] ST_REP_WAIT     = 4'd7;
   localparam logic [3:0] ST_END          = 4'd8;

   typedef struct packed {
      logic [3:0] key_pins;
      logic [3:0] read_ack;
   } req_type;

   typedef struct packed {
      logic [3:0] ready_mask;
      logic [3:0] pressed_mask;
      logic [3:0] long_press_mask;
      logic [3:0] busy_mask;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  debounce_ticks;
      logic [15:0] repeat_start_ticks;
      logic [15:0] repeat_period_ticks;
      logic [15:0] long_press_ticks;
   } timing_type;

   typedef struct packed {
      logic ready;
      logic pressed;
      logic long_press;
      logic busy;
   } key_status_type;

endpackage

// ===== hw/rtl/kde_key_lane.sv =====
// ---------------------------------------------------------------------------
// Keypad key lane
// Debounce and event machine of one key; passes the group lock vector on.
// ---------------------------------------------------------------------------
module kde_key_lane
   import kde_pkg::*;
#(
   parameter int NUM_GROUPS      = KDE_NUM_GROUPS,
   parameter int HOLD_COUNT_BITS = KDE_HOLD_COUNT_BITS,
   localparam int GW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  pressed_raw,
   input  logic                  ack,
   input  logic [3:0]            mode,
   input  logic [GW-1:0]         group,
   input  timing_type            timing,
   input  logic [NUM_GROUPS-1:0] lock_in,
   output logic [NUM_GROUPS-1:0] lock_out,
   output key_status_type        status
);

   logic [1:0]                 db_stage_ff, db_stage_in;
   logic [7:0]                 db_count_ff, db_count_in;
   logic                       stable_ff, stable_in;
   logic [3:0]                 stage_ff, stage_in;
   logic [HOLD_COUNT_BITS-1:0] hold_ff, hold_in;
   logic                       ready_ff, ready_in;
   logic                       after_ff, after_in;
   logic                       owner_ff, owner_in;
   logic                       busy_ff, busy_in;

   always_comb begin
      logic [7:0] dc;
      logic       rep;
      logic       grouped;
      dc = db_count_ff;
      db_stage_in = db_stage_ff;
      db_count_in = db_count_ff;
      stable_in = stable_ff;
      case (db_stage_ff)
         DB_IDLE: begin
            if (pressed_raw) db_stage_in = DB_PRESSING;
         end
         DB_PRESSING, DB_RELEASE: begin
            if (dc != 8'hFF) dc = dc + 8'd1;
            db_count_in = dc;
            if (dc >= timing.debounce_ticks) begin
               db_count_in = 8'd0;
               if (db_stage_ff == DB_PRESSING) begin
                  if (pressed_raw) begin
                     stable_in = 1'b1;
                     db_stage_in = DB_HELD;
                  end else begin
                     db_stage_in = DB_IDLE;
                  end
               end else begin
                  if (pressed_raw) begin
                     db_stage_in = DB_HELD;
                  end else begin
                     stable_in = 1'b0;
                     db_stage_in = DB_IDLE;
                  end
               end
            end
         end
         default: begin
            if (!pressed_raw) db_stage_in = DB_RELEASE;
         end
      endcase

      rep = mode[3];
      grouped = (group != '0);
      lock_out = lock_in;
      stage_in = stage_ff;
      hold_in = hold_ff;
      ready_in = ready_ff & ~ack;
      after_in = after_ff;
      owner_in = owner_ff;
      busy_in = busy_ff;

      if (stage_in == ST_START && stable_in && mode[2:0] != 3'd0) begin
         if (!(grouped && lock_in[group] && !owner_ff)) begin
            if (mode[0]) begin
               ready_in = 1'b1;
               stage_in = rep ? ST_REP_START : ST_WAIT_RELEASE;
            end else if (mode[1]) begin
               stage_in = ST_ON_RELEASE;
            end else begin
               stage_in = ST_LONG;
            end
            busy_in = 1'b1;
            if (grouped) begin
               lock_out[group] = 1'b1;
               owner_in = 1'b1;
            end
         end
      end
      if ((stage_in == ST_REP_START || stage_in == ST_REP_ARM || stage_in == ST_REP_WAIT)
          && !stable_in) begin
         hold_in = '0;
         stage_in = ST_WAIT_READ;
      end
      if (stage_in == ST_REP_START) begin
         if (hold_in != '1) hold_in = hold_in + 1'b1;
         if (32'(hold_in) >= 32'(timing.repeat_start_ticks)) begin
            hold_in = '0;
            stage_in = ST_REP_ARM;
         end
      end
      if (stage_in == ST_REP_ARM && !ready_in) begin
         ready_in = 1'b1;
         stage_in = ST_REP_WAIT;
      end
      if (stage_in == ST_REP_WAIT) begin
         if (hold_in != '1) hold_in = hold_in + 1'b1;
         if (32'(hold_in) >= 32'(timing.repeat_period_ticks)) begin
            hold_in = '0;
            stage_in = ST_REP_ARM;
         end
      end
      if (stage_in == ST_ON_RELEASE && !stable_in) begin
         ready_in = 1'b1;
         stage_in = ST_WAIT_READ;
      end
      if (stage_in == ST_LONG) begin
         if (hold_in != '1) hold_in = hold_in + 1'b1;
         if (!stable_in && 32'(hold_in) <= 32'(timing.long_press_ticks)) begin
            hold_in = '0;
            ready_in = 1'b1;
            after_in = 1'b0;
            stage_in = ST_WAIT_READ;
         end
         if (32'(hold_in) > 32'(timing.long_press_ticks)) begin
            hold_in = '0;
            ready_in = 1'b1;
            after_in = 1'b1;
            stage_in = rep ? ST_REP_WAIT : ST_WAIT_RELEASE;
         end
      end
      if (stage_in == ST_WAIT_RELEASE && !stable_in) stage_in = ST_WAIT_READ;
      if (stage_in == ST_WAIT_READ && !ready_in) stage_in = ST_END;
      if (stage_in == ST_END) begin
         if (grouped) begin
            lock_out[group] = 1'b0;
            owner_in = 1'b0;
         end
         stage_in = ST_START;
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         db_stage_ff <= DB_IDLE;
         db_count_ff <= 8'd0;
         stable_ff <= 1'b0;
         stage_ff <= ST_START;
         hold_ff <= '0;
         ready_ff <= 1'b0;
         after_ff <= 1'b0;
         owner_ff <= 1'b0;
         busy_ff <= 1'b0;
      end else if (advance) begin
         db_stage_ff <= db_stage_in;
         db_count_ff <= db_count_in;
         stable_ff <= stable_in;
         stage_ff <= stage_in;
         hold_ff <= hold_in;
         ready_ff <= ready_in;
         after_ff <= after_in;
         owner_ff <= owner_in;
         busy_ff <= busy_in;
      end
   end

   assign status.ready = ready_ff;
   assign status.pressed = stable_ff;
   assign status.long_press = after_ff;
   assign status.busy = busy_ff;

`include "keypad_debounce_event_engine_macros.svh"

   `KDE_ASSERT_ALWAYS(a_busy_matches_stage, busy_ff == (stage_ff != ST_START), "busy mismatch")
   `KDE_ASSERT_ALWAYS(a_held_pressed, db_stage_ff != DB_HELD || stable_ff, "held not pressed")
   `KDE_ASSERT_ALWAYS(a_idle_released, db_stage_ff != DB_IDLE || !stable_ff, "idle pressed")

endmodule

// ===== hw/rtl/keypad_debounce_event_engine.sv =====
// ---------------------------------------------------------------------------
// Keypad debounce event engine
// Four-key debounce with press, release, long-press and autorepeat events.
// ---------------------------------------------------------------------------
// One item is one tick and yields one result item. Ticks are taken one per
// cycle, back to back: all key lanes work side by side and
// the group lock vector ripples through the lanes in key order, so a lower
// key wins group contention. The result is read straight from the lane state
// registers, which hold while it waits; a new item is taken whenever no
// result is waiting or the waiting one is being drained.
module keypad_debounce_event_engine
   import kde_pkg::*;
#(
   parameter int NUM_KEYS        = KDE_NUM_KEYS,
   parameter int NUM_GROUPS      = KDE_NUM_GROUPS,
   parameter int HOLD_COUNT_BITS = KDE_HOLD_COUNT_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_data,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int GW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

   logic [15:0]           modes_ff;
   logic [7:0]            groups_ff;
   timing_type            timing_ff;
   logic [NUM_GROUPS-1:0] locked_ff;
   logic                  rsp_valid_ff;
   logic                  advance;

   logic [NUM_GROUPS-1:0] lock_chain [NUM_KEYS+1];
   key_status_type        status [NUM_KEYS];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign advance = req_valid && req_ready;
   assign lock_chain[0] = locked_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         modes_ff <= 16'd0;
         groups_ff <= 8'd0;
         timing_ff.debounce_ticks <= DEBOUNCE_TICKS_RESET;
         timing_ff.repeat_start_ticks <= REPEAT_START_RESET;
         timing_ff.repeat_period_ticks <= REPEAT_PERIOD_RESET;
         timing_ff.long_press_ticks <= LONG_PRESS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_KEY_MODES:      modes_ff <= csr_wdata;
            CSR_KEY_GROUPS:     groups_ff <= csr_wdata[7:0];
            CSR_DEBOUNCE_TICKS: timing_ff.debounce_ticks <= csr_wdata[7:0];
            CSR_REPEAT_START:   timing_ff.repeat_start_ticks <= csr_wdata;
            CSR_REPEAT_PERIOD:  timing_ff.repeat_period_ticks <= csr_wdata;
            CSR_LONG_PRESS:     timing_ff.long_press_ticks <= csr_wdata;
            default: ;
         endcase
      end
   end

   for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
      logic [3:0]    mode;
      logic [1:0]    grp_raw;
      logic [GW-1:0] grp;
      logic          pin_pressed;
      logic          ack;
      if (k < 4) begin : g_wired
         assign mode = modes_ff[4*k +: 4];
         assign grp_raw = groups_ff[2*k +: 2];
         assign pin_pressed = !req_data.key_pins[k];
         assign ack = req_data.read_ack[k];
      end else begin : g_unwired
         assign mode = 4'd0;
         assign grp_raw = 2'd0;
         assign pin_pressed = 1'b0;
         assign ack = 1'b0;
      end
      // out-of-range group numbers act as ungrouped
      assign grp = (int'(grp_raw) < NUM_GROUPS) ? GW'(grp_raw) : '0;

      kde_key_lane #(
         .NUM_GROUPS      (NUM_GROUPS),
         .HOLD_COUNT_BITS (HOLD_COUNT_BITS)
      ) u_lane (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .pressed_raw (pin_pressed),
         .ack         (ack),
         .mode        (mode),
         .group       (grp),
         .timing      (timing_ff),
         .lock_in     (lock_chain[k]),
         .lock_out    (lock_chain[k+1]),
         .status      (status[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         locked_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) locked_ff <= lock_chain[NUM_KEYS];
         if (advance) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // lane state holds the values after the last accepted tick
   always_comb begin
      rsp_data = '0;
      for (int k = 0; k < NUM_KEYS && k < 4; k++) begin
         rsp_data.ready_mask[k] = status[k].ready;
         rsp_data.pressed_mask[k] = status[k].pressed;
         rsp_data.long_press_mask[k] = status[k].long_press;
         rsp_data.busy_mask[k] = status[k].busy;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`include "keypad_debounce_event_engine_macros.svh"

   `KDE_ASSERT_NEXT(a_accept_gives_result, advance, rsp_valid_ff, "result missing")
   `KDE_ASSERT_NEXT(a_hold_result, rsp_valid_ff && !rsp_ready, rsp_valid_ff, "result dropped")
   `KDE_ASSERT_ALWAYS(a_group0_free, !locked_ff[0], "group zero locked")

endmodule

// ===== dv/testbench.sv =====
// ---------------------------------------------------------------------------
// Keypad debounce event engine testbench
// Directed ticks from a table, then phases of random key activity under
// changing register settings. Every result item is checked against an
// in-bench model of the debounce and event machines, or against the table
// row's own value where a row gives one. Both handshakes stall at random.
// ---------------------------------------------------------------------------
module testbench;
   import kde_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASES      = 9;
   localparam int PHASE_TICKS = 160;

   typedef struct {
      logic [3:0] pins;
      logic [3:0] ack;
      bit         typed;
      rsp_type    want;
   } tick_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   req_type                   req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // register copies and key state of the in-bench model
   logic [15:0] cfg_modes, cfg_rep_start, cfg_rep_period, cfg_long;
   logic [7:0]  cfg_groups, cfg_debounce;
   logic [1:0]  db_stage [4];
   logic [7:0]  db_count [4];
   logic [3:0]  ev_stage [4];
   logic [15:0] hold_cnt [4];
   bit          stable [4], flag_ready [4], after_thr [4], owner [4], busy [4];
   bit          locked [4];

   rsp_type tick_expect_q [$];
   int      error_count = 0;
   int      cycle_count = 0;
   int      sent_count = 0;
   int      seen_count = 0;
   bit      sender_quiet = 1'b0;

   // directed ticks: key0 press, key1 on release, key2 long press,
   // key3 press with repeat; keys 0 and 1 share a group
   tick_row_type dir_rows [21] = '{
      '{4'hF, 4'h0, 1'b1, 16'h0000},
      '{4'h0, 4'hF, 1'b1, 16'h0000},
      '{4'h0, 4'h0, 1'b0, 16'h0000},
      '{4'h0, 4'h0, 1'b0, 16'h0000},
      '{4'h0, 4'hF, 1'b0, 16'h0000},
      '{4'h0, 4'h0, 1'b0, 16'h0000},
      '{4'hF, 4'h0, 1'b0, 16'h0000},
      '{4'hF, 4'h0, 1'b0, 16'h0000},
      '{4'hF, 4'hF, 1'b0, 16'h0000},
      '{4'hF, 4'h0, 1'b0, 16'h0000},
      '{4'hE, 4'h0, 1'b0, 16'h0000},
      '{4'hE, 4'h0, 1'b0, 16'h0000},
      '{4'hE, 4'h1, 1'b0, 16'h0000},
      '{4'hF, 4'h0, 1'b0, 16'h0000},
      '{4'hF, 4'h1, 1'b0, 16'h0000},
      '{4'hD, 4'h0, 1'b0, 16'h0000},
      '{4'hD, 4'h0, 1'b0, 16'h0000},
      '{4'hF, 4'h0, 1'b0, 16'h0000},
      '{4'hF, 4'h0, 1'b0, 16'h0000},
      '{4'hF, 4'h2, 1'b0, 16'h0000},
      '{4'hF, 4'h0, 1'b0, 16'h0000}
   };

   keypad_debounce_event_engine i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic clear_keys();
      cfg_modes = '0;
      cfg_groups = '0;
      cfg_debounce = DEBOUNCE_TICKS_RESET;
      cfg_rep_start = REPEAT_START_RESET;
      cfg_rep_period = REPEAT_PERIOD_RESET;
      cfg_long = LONG_PRESS_RESET;
      for (int k = 0; k < 4; k++) begin
         db_stage[k] = DB_IDLE;
         db_count[k] = '0;
         ev_stage[k] = ST_START;
         hold_cnt[k] = '0;
         stable[k] = 0; flag_ready[k] = 0; after_thr[k] = 0;
         owner[k] = 0; busy[k] = 0; locked[k] = 0;
      end
   endtask

   function automatic logic [15:0] bump_hold(int k);
      if (hold_cnt[k] != 16'hFFFF) hold_cnt[k]++;
      return hold_cnt[k];
   endfunction

   function automatic void debounce_key(int k, bit down);
      case (db_stage[k])
         DB_IDLE: begin
            if (down) db_stage[k] = DB_PRESSING;
         end
         DB_PRESSING, DB_RELEASE: begin
            if (db_count[k] != 8'hFF) db_count[k]++;
            if (db_count[k] >= cfg_debounce) begin
               db_count[k] = '0;
               if (db_stage[k] == DB_PRESSING) begin
                  if (down) begin
                     stable[k] = 1;
                     db_stage[k] = DB_HELD;
                  end else db_stage[k] = DB_IDLE;
               end else begin
                  if (down) db_stage[k] = DB_HELD;
                  else begin
                     stable[k] = 0;
                     db_stage[k] = DB_IDLE;
                  end
               end
            end
         end
         default: begin
            if (!down) db_stage[k] = DB_RELEASE;
         end
      endcase
   endfunction

   function automatic void run_event(int k);
      logic [3:0] m;
      logic [1:0] g;
      bit         rep;
      m = cfg_modes[4*k +: 4];
      g = cfg_groups[2*k +: 2];
      rep = m[3];
      if (ev_stage[k] == ST_START && stable[k] && m[2:0] != 0
          && !(g != 0 && locked[g] && !owner[k])) begin
         if (m[0]) begin
            flag_ready[k] = 1;
            ev_stage[k] = rep ? ST_REP_START : ST_WAIT_RELEASE;
         end else if (m[1]) ev_stage[k] = ST_ON_RELEASE;
         else ev_stage[k] = ST_LONG;
         busy[k] = 1;
         if (g != 0) begin
            locked[g] = 1;
            owner[k] = 1;
         end
      end
      if (ev_stage[k] >= ST_REP_START && ev_stage[k] <= ST_REP_WAIT && !stable[k]) begin
         hold_cnt[k] = '0;
         ev_stage[k] = ST_WAIT_READ;
      end
      if (ev_stage[k] == ST_REP_START && bump_hold(k) >= cfg_rep_start) begin
         hold_cnt[k] = '0;
         ev_stage[k] = ST_REP_ARM;
      end
      if (ev_stage[k] == ST_REP_ARM && !flag_ready[k]) begin
         flag_ready[k] = 1;
         ev_stage[k] = ST_REP_WAIT;
      end
      if (ev_stage[k] == ST_REP_WAIT && bump_hold(k) >= cfg_rep_period) begin
         hold_cnt[k] = '0;
         ev_stage[k] = ST_REP_ARM;
      end
      if (ev_stage[k] == ST_ON_RELEASE && !stable[k]) begin
         flag_ready[k] = 1;
         ev_stage[k] = ST_WAIT_READ;
      end
      if (ev_stage[k] == ST_LONG) begin
         void'(bump_hold(k));
         if (!stable[k] && hold_cnt[k] <= cfg_long) begin
            hold_cnt[k] = '0;
            flag_ready[k] = 1;
            after_thr[k] = 0;
            ev_stage[k] = ST_WAIT_READ;
         end
         if (hold_cnt[k] > cfg_long) begin
            hold_cnt[k] = '0;
            flag_ready[k] = 1;
            after_thr[k] = 1;
            ev_stage[k] = rep ? ST_REP_WAIT : ST_WAIT_RELEASE;
         end
      end
      if (ev_stage[k] == ST_WAIT_RELEASE && !stable[k]) ev_stage[k] = ST_WAIT_READ;
      if (ev_stage[k] == ST_WAIT_READ && !flag_ready[k]) ev_stage[k] = ST_END;
      if (ev_stage[k] == ST_END) begin
         // unlock the group named now, even if it changed mid-event
         if (g != 0) begin
            locked[g] = 0;
            owner[k] = 0;
         end
         ev_stage[k] = ST_START;
         busy[k] = 0;
      end
   endfunction

   function automatic rsp_type advance_keypad(req_type r);
      rsp_type o;
      for (int k = 0; k < 4; k++) if (r.read_ack[k]) flag_ready[k] = 0;
      for (int k = 0; k < 4; k++) debounce_key(k, !r.key_pins[k]);
      for (int k = 0; k < 4; k++) run_event(k);
      for (int k = 0; k < 4; k++) begin
         o.ready_mask[k] = flag_ready[k];
         o.pressed_mask[k] = stable[k];
         o.long_press_mask[k] = after_thr[k];
         o.busy_mask[k] = busy[k];
      end
      return o;
   endfunction

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_KEY_MODES:      cfg_modes = val;
         CSR_KEY_GROUPS:     cfg_groups = val[7:0];
         CSR_DEBOUNCE_TICKS: cfg_debounce = val[7:0];
         CSR_REPEAT_START:   cfg_rep_start = val;
         CSR_REPEAT_PERIOD:  cfg_rep_period = val;
         CSR_LONG_PRESS:     cfg_long = val;
         default: ;
      endcase
   endtask

   task automatic write_setting(logic [15:0] modes, logic [7:0] groups, logic [7:0] db,
                                logic [15:0] rstart, logic [15:0] rper, logic [15:0] lng);
      write_reg(CSR_KEY_MODES, modes);
      write_reg(CSR_KEY_GROUPS, {8'h00, groups});
      write_reg(CSR_DEBOUNCE_TICKS, {8'h00, db});
      write_reg(CSR_REPEAT_START, rstart);
      write_reg(CSR_REPEAT_PERIOD, rper);
      write_reg(CSR_LONG_PRESS, lng);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // valid stays high across back-to-back items; drop happens only on a gap
   task automatic send_tick(req_type r, bit typed, rsp_type want);
      int      gap;
      rsp_type predicted;
      gap = sender_quiet ? 0 : $urandom_range(0, 6);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      predicted = advance_keypad(r);
      tick_expect_q.push_back(typed ? want : predicted);
      sent_count++;
      sender_quiet = ((sent_count / 90) % 4) == 3;
   endtask

   task automatic drain_ticks();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tick_expect_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic random_phase(int p);
      logic [3:0] level, noise;
      int         run_left [4];
      int         max_run;
      req_type    r;
      case (p)
         0: write_setting(16'h0000, 8'h00, 8'd0, 16'd0, 16'd0, 16'd0);
         1: write_setting(16'hFFFF, 8'hFF, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
         2: write_setting(16'hFFFF, 8'h00, 8'd1, 16'd1, 16'd1, 16'd0);
         default: write_setting(16'($urandom_range(0, 16'hFFFF)), 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 4)), 16'($urandom_range(0, 25)),
                                16'($urandom_range(0, 8)), 16'($urandom_range(0, 30)));
      endcase
      max_run = 4 * cfg_debounce + 40;
      level = 4'hF;
      for (int k = 0; k < 4; k++) run_left[k] = 0;
      for (int t = 0; t < PHASE_TICKS; t++) begin
         for (int k = 0; k < 4; k++) begin
            if (run_left[k] == 0) begin
               level[k] = ~level[k];
               // short bursts model contact bounce
               run_left[k] = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(1, max_run);
            end
            run_left[k]--;
         end
         noise = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'h0;
         r.key_pins = level ^ noise;
         r.read_ack = 4'($urandom_range(0, 15)) & 4'($urandom_range(0, 15));
         send_tick(r, 1'b0, '0);
      end
      drain_ticks();
   endtask

   // result side: random stalls, one long hold-off to back up the block
   initial begin
      int      gap;
      rsp_type want;
      bit      held;
      held = 0;
      forever begin
         gap = (((seen_count / 70) % 3) == 1) ? 0 : $urandom_range(0, 6);
         if (!held && seen_count == 400) begin
            held = 1;
            gap = 120;
         end
         @(negedge clock);
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         seen_count++;
         if (tick_expect_q.size() == 0) begin
            $error("result item with nothing expected: %h", rsp_data);
            error_count++;
         end else begin
            want = tick_expect_q.pop_front();
            if (rsp_data.ready_mask !== want.ready_mask) begin
               $error("ready_mask expected %h actual %h", want.ready_mask, rsp_data.ready_mask);
               error_count++;
            end
            if (rsp_data.pressed_mask !== want.pressed_mask) begin
               $error("pressed_mask expected %h actual %h",
                      want.pressed_mask, rsp_data.pressed_mask);
               error_count++;
            end
            if (rsp_data.long_press_mask !== want.long_press_mask) begin
               $error("long_press_mask expected %h actual %h",
                      want.long_press_mask, rsp_data.long_press_mask);
               error_count++;
            end
            if (rsp_data.busy_mask !== want.busy_mask) begin
               $error("busy_mask expected %h actual %h", want.busy_mask, rsp_data.busy_mask);
               error_count++;
            end
         end
      end
   end

   initial begin
      req_type r;
      clear_keys();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // groups: keys 0 and 1 in group 1, key 2 in group 2; zero long-press threshold
      write_setting(16'h9421, 8'h25, 8'd1, 16'd1, 16'd1, 16'd0);
      foreach (dir_rows[i]) begin
         r.key_pins = dir_rows[i].pins;
         r.read_ack = dir_rows[i].ack;
         send_tick(r, dir_rows[i].typed, dir_rows[i].want);
      end
      drain_ticks();
      for (int p = 0; p < PHASES; p++) random_phase(p);
      repeat (10) @(posedge clock);
      if (error_count == 0 && tick_expect_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
